/* hdl/vcm_pkg.sv */
// ============================================================================
// vcm_pkg: shared types and constants of the vertical comb mask
// Register map codes, field widths and the control structs passed between
// the front end, the queue and the arithmetic back end.
// ============================================================================
package vcm_pkg;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int THRES_W  = 25;
    localparam int DEPTH_W  = 5;
    localparam int FW_W     = 13;
    localparam int FH_W     = 16;
    localparam int MASK_W   = 16;
    localparam int Q_DEPTH  = 4;

    localparam int BASE_DEPTH = 8;
    localparam int TOP_DEPTH  = 16;
    localparam int CLAMP8     = 255;
    localparam int FRAC_SHIFT = 8;

    localparam logic [THRES_W-1:0] THRES_LOW_RST  = 25'd0;
    localparam logic [THRES_W-1:0] THRES_HIGH_RST = 25'd255;
    localparam logic [DEPTH_W-1:0] DEPTH_RST      = 5'd8;
    localparam logic [FW_W-1:0]    WIDTH_RST      = 13'd1920;
    localparam logic [FH_W-1:0]    HEIGHT_RST     = 16'd1080;

    typedef enum logic [2:0] {
        REG_THRES_LOW    = 3'd0,
        REG_THRES_HIGH   = 3'd1,
        REG_BIT_DEPTH    = 3'd2,
        REG_FRAME_WIDTH  = 3'd3,
        REG_FRAME_HEIGHT = 3'd4
    } vcm_reg_t;

    typedef struct packed {
        logic compute;
        logic last_row;
        logic last_col;
    } vcm_flags_t;

    typedef struct packed {
        logic [FW_W-1:0] frame_width;
        logic [FH_W-1:0] frame_height;
    } vcm_geom_t;

    typedef struct packed {
        logic [THRES_W-1:0] thres_low;
        logic [THRES_W-1:0] thres_high;
        logic [DEPTH_W-1:0] bit_depth;
    } vcm_cfg_t;

endpackage

/* hdl/vcm_if.sv */
// ============================================================================
// vcm_if: valid/ready stream interfaces
// Pixel input channel and mask output channel of the vertical comb mask.
// ============================================================================
interface vcm_pixel_if #(parameter int PIXEL_BITS = 16) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface vcm_mask_if ();
    logic        valid;
    logic        ready;
    logic [15:0] mask_value;
    logic        end_of_run;
    logic        end_of_frame;

    modport source (output valid, output mask_value, output end_of_run,
                    output end_of_frame, input ready);
    modport sink (input valid, input mask_value, input end_of_run,
                  input end_of_frame, output ready);
endinterface

/* hdl/vertical_comb_mask.sv */
// ============================================================================
// vertical_comb_mask: three-line combing mask
// Pixels enter in raster order on the pixels channel; mask results leave on
// the masks channel one row behind, one per pixel, two per pixel on the last
// row (the second is the zero bottom-row mask, flagged at the frame's end).
// Each transfer is a valid/ready handshake. An APB port holds thresholds,
// bit depth and frame geometry; write it only while the block is idle.
// Throughput is one pixel per clock while the receiver takes every result,
// set by the single-ported line-store reads and the one multiplier; on the
// last row each pixel gives two results, so the input is then held back.
// From pixel transfer to its first mask result the path runs through the
// line store read, queue, product register, scale and threshold register
// and output register.
// Reset clears row and column position, loads configuration defaults;
// the line stores are not cleared and hold no data until the first rows
// pass. When the receiver stalls, the output register, pipeline and the
// four-entry queue fill in turn and ready drops on the pixels channel.
// ============================================================================
module vertical_comb_mask
    import vcm_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    vcm_pixel_if.sink         pixels,
    vcm_mask_if.source        masks,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int QW = 3 * PIXEL_BITS + $bits(vcm_flags_t);

    logic [THRES_W-1:0] thres_low_reg;
    logic [THRES_W-1:0] thres_high_reg;
    logic [DEPTH_W-1:0] bit_depth_reg;
    logic [FW_W-1:0]    frame_width_reg;
    logic [FH_W-1:0]    frame_height_reg;

    vcm_reg_t              reg_idx;
    logic                  wr_en;
    vcm_geom_t             geom;
    vcm_cfg_t              cfg;
    logic                  q_push;
    logic                  q_full;
    logic                  q_almost_full;
    logic                  q_pop_valid;
    logic                  q_pop_ready;
    logic [QW-1:0]         q_push_data;
    logic [QW-1:0]         q_pop_data;
    logic [PIXEL_BITS-1:0] f_a, f_c, f_b;
    vcm_flags_t            f_flags;
    logic [PIXEL_BITS-1:0] b_a, b_c, b_b;
    vcm_flags_t            b_flags;

    assign reg_idx = vcm_reg_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thres_low_reg    <= THRES_LOW_RST;
            thres_high_reg   <= THRES_HIGH_RST;
            bit_depth_reg    <= DEPTH_RST;
            frame_width_reg  <= WIDTH_RST;
            frame_height_reg <= HEIGHT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_THRES_LOW:    thres_low_reg    <= pwdata[THRES_W-1:0];
                REG_THRES_HIGH:   thres_high_reg   <= pwdata[THRES_W-1:0];
                REG_BIT_DEPTH:    bit_depth_reg    <= pwdata[DEPTH_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_THRES_LOW:    prdata = DATA_W'(thres_low_reg);
            REG_THRES_HIGH:   prdata = DATA_W'(thres_high_reg);
            REG_BIT_DEPTH:    prdata = DATA_W'(bit_depth_reg);
            REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    assign geom.frame_width  = frame_width_reg;
    assign geom.frame_height = frame_height_reg;
    assign cfg.thres_low     = thres_low_reg;
    assign cfg.thres_high    = thres_high_reg;
    assign cfg.bit_depth     = bit_depth_reg;

    vcm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixels        (pixels),
        .geom          (geom),
        .q_full        (q_full),
        .q_almost_full (q_almost_full),
        .push          (q_push),
        .push_a        (f_a),
        .push_c        (f_c),
        .push_b        (f_b),
        .push_flags    (f_flags)
    );

    assign q_push_data = {f_a, f_c, f_b, f_flags};

    vcm_fifo #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (q_push),
        .push_data   (q_push_data),
        .full        (q_full),
        .almost_full (q_almost_full),
        .pop_valid   (q_pop_valid),
        .pop_ready   (q_pop_ready),
        .pop_data    (q_pop_data)
    );

    assign {b_a, b_c, b_b, b_flags} = q_pop_data;

    vcm_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_pop_valid),
        .in_ready (q_pop_ready),
        .in_a     (b_a),
        .in_c     (b_c),
        .in_b     (b_b),
        .in_flags (b_flags),
        .cfg      (cfg),
        .masks    (masks)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
    else $error("queue written while full");

    assert property (@(posedge clk) disable iff (!rst_n)
        masks.valid && masks.end_of_frame |-> masks.end_of_run && (masks.mask_value == '0))
    else $error("frame end flagged on a non-final or nonzero result");

    assert property (@(posedge clk) disable iff (!rst_n)
        masks.valid && masks.ready && !masks.end_of_run
        |=> masks.valid && masks.end_of_run)
    else $error("first result of a pixel not followed by its final result");

endmodule

/* hdl/vcm_front.sv */
// ============================================================================
// vcm_front: raster tracking and line stores
// Accepts pixels, tracks row and column, reads and updates the two line
// stores and hands each pixel with its neighbors and flags to the queue.
// ============================================================================
module vcm_front
    import vcm_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    vcm_pixel_if.sink             pixels,
    input  vcm_geom_t             geom,
    input  logic                  q_full,
    input  logic                  q_almost_full,
    output logic                  push,
    output logic [PIXEL_BITS-1:0] push_a,
    output logic [PIXEL_BITS-1:0] push_c,
    output logic [PIXEL_BITS-1:0] push_b,
    output vcm_flags_t            push_flags
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (XW + 1 > FW_W) ? XW + 1 : FW_W;

    logic [XW-1:0]         col_reg, col_next;
    logic [FH_W-1:0]       row_reg, row_next;
    logic                  s1_valid_reg, s1_valid_next;
    logic [XW-1:0]         s1_x_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    vcm_flags_t            s1_flags_reg;
    logic                  s1_emit_reg;
    logic                  fwd_reg;
    logic [PIXEL_BITS-1:0] fwd_data_reg;
    logic [PIXEL_BITS-1:0] one_rd_reg;
    logic [PIXEL_BITS-1:0] two_rd_reg;
    logic [PIXEL_BITS-1:0] one_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] two_mem [MAX_WIDTH];

    logic                  accept;
    logic [CMPW-1:0]       col_p1;
    logic [FH_W:0]         row_p1;
    logic                  last_col;
    logic                  last_row;

    assign accept   = pixels.valid && pixels.ready;
    assign col_p1   = CMPW'(col_reg) + CMPW'(1);
    assign row_p1   = (FH_W + 1)'(row_reg) + (FH_W + 1)'(1);
    assign last_col = (col_p1 >= CMPW'(geom.frame_width))
                      || (col_reg == XW'(MAX_WIDTH - 1));
    assign last_row = (row_reg != '0) && (row_p1 >= (FH_W + 1)'(geom.frame_height));

    assign pixels.ready = !q_full && !(q_almost_full && s1_valid_reg);

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        s1_valid_next = accept;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_p1[FH_W-1:0];
            end
            else
            begin
                col_next = col_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Line stores: the upper row is refreshed in the cycle after the read, so a
    // back-to-back pixel at the same column takes the value being written.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            one_rd_reg       <= one_mem[col_reg];
            two_rd_reg       <= two_mem[col_reg];
            one_mem[col_reg] <= pixels.pixel;
        end
        if (s1_valid_reg)
        begin
            two_mem[s1_x_reg] <= one_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg              <= col_reg;
            s1_pix_reg            <= pixels.pixel;
            s1_emit_reg           <= (row_reg != '0);
            s1_flags_reg.compute  <= (row_reg >= FH_W'(2));
            s1_flags_reg.last_row <= last_row;
            s1_flags_reg.last_col <= last_col;
            fwd_reg               <= s1_valid_reg && (s1_x_reg == col_reg);
            fwd_data_reg          <= one_rd_reg;
        end
    end

    assign push       = s1_valid_reg && s1_emit_reg;
    assign push_a     = fwd_reg ? fwd_data_reg : two_rd_reg;
    assign push_c     = one_rd_reg;
    assign push_b     = s1_pix_reg;
    assign push_flags = s1_flags_reg;

endmodule

/* hdl/vcm_fifo.sv */
// ============================================================================
// vcm_fifo: short queue between front end and back end
// Small register queue with full and almost-full flags for credit control.
// ============================================================================
module vcm_fifo
    import vcm_pkg::*;
#(
    parameter int WIDTH = 51,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             almost_full,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             pop;

    assign full        = (count_reg == (PW + 1)'(DEPTH));
    assign almost_full = (count_reg >= (PW + 1)'(DEPTH - 1));
    assign pop_valid   = (count_reg != '0);
    assign pop         = pop_valid && pop_ready;
    assign pop_data    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (PW + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/vcm_back.sv */
// ============================================================================
// vcm_back: mask arithmetic and result output
// Multiplies the neighbor differences, scales and thresholds the product,
// and emits one or two mask results per item through an output register.
// ============================================================================
module vcm_back
    import vcm_pkg::*;
#(
    parameter int PIXEL_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIXEL_BITS-1:0] in_a,
    input  logic [PIXEL_BITS-1:0] in_c,
    input  logic [PIXEL_BITS-1:0] in_b,
    input  vcm_flags_t            in_flags,
    input  vcm_cfg_t              cfg,
    vcm_mask_if.source            masks
);

    localparam int PW = 2 * (PIXEL_BITS + 1);
    localparam int MW = (PW > THRES_W) ? PW : THRES_W;

    logic                    b1_valid_reg, b1_valid_next;
    logic signed [PW-1:0]    b1_prod_reg;
    vcm_flags_t              b1_flags_reg;
    logic                    b2_valid_reg, b2_valid_next;
    logic [MASK_W-1:0]       b2_mask_reg;
    vcm_flags_t              b2_flags_reg;
    logic                    o_valid_reg, o_valid_next;
    logic                    o_phase_reg, o_phase_next;
    logic [MASK_W-1:0]       o_mask_reg;
    logic                    o_last_row_reg;
    logic                    o_last_col_reg;

    logic signed [PIXEL_BITS:0] d1;
    logic signed [PIXEL_BITS:0] d2;
    logic signed [PW-1:0]       prod;
    logic [DEPTH_W-1:0]         depth;
    logic [3:0]                 sh;
    logic signed [MW-1:0]       pe;
    logic signed [MW-1:0]       ps;
    logic signed [MW-1:0]       v;
    logic signed [MW-1:0]       tl;
    logic signed [MW-1:0]       th;
    logic signed [MW-1:0]       cmax_s;
    logic [MASK_W-1:0]          cmax;
    logic [MASK_W-1:0]          peak;
    logic [MASK_W-1:0]          mask;
    logic                       out_free;
    logic                       b2_en;
    logic                       b1_en;

    assign d1   = $signed({1'b0, in_a}) - $signed({1'b0, in_c});
    assign d2   = $signed({1'b0, in_b}) - $signed({1'b0, in_c});
    assign prod = d1 * d2;

    always_comb
    begin
        priority if (cfg.bit_depth < DEPTH_W'(BASE_DEPTH))
        begin
            depth = DEPTH_W'(BASE_DEPTH);
        end
        else if (cfg.bit_depth > DEPTH_W'(TOP_DEPTH))
        begin
            depth = DEPTH_W'(TOP_DEPTH);
        end
        else
        begin
            depth = cfg.bit_depth;
        end
    end

    assign sh     = 4'(depth - DEPTH_W'(BASE_DEPTH));
    assign pe     = MW'(b1_prod_reg);
    assign ps     = pe >>> sh;
    assign v      = ps >>> FRAC_SHIFT;
    assign tl     = MW'($signed(cfg.thres_low));
    assign th     = MW'($signed(cfg.thres_high));
    assign cmax   = (depth == DEPTH_W'(BASE_DEPTH)) ? MASK_W'(CLAMP8) : '1;
    assign cmax_s = $signed(MW'(cmax));
    assign peak   = MASK_W'((17'(1) << depth) - 17'(1));

    always_comb
    begin
        priority if (!b1_flags_reg.compute)
        begin
            mask = '0;
        end
        else if (ps < tl)
        begin
            mask = '0;
        end
        else if (ps > th)
        begin
            mask = peak;
        end
        else if (v < 0)
        begin
            mask = '0;
        end
        else if (v > cmax_s)
        begin
            mask = cmax;
        end
        else
        begin
            mask = v[MASK_W-1:0];
        end
    end

    // The last row gives a second, all-zero bottom-row result per item.
    assign out_free = !o_valid_reg
                      || (masks.ready && (o_phase_reg || !o_last_row_reg));
    assign b2_en    = !b2_valid_reg || out_free;
    assign b1_en    = !b1_valid_reg || b2_en;
    assign in_ready = b1_en;

    always_comb
    begin
        b1_valid_next = b1_en ? in_valid : b1_valid_reg;
        b2_valid_next = b2_en ? b1_valid_reg : b2_valid_reg;
        o_valid_next  = out_free ? b2_valid_reg : o_valid_reg;
        o_phase_next  = o_phase_reg;
        if (out_free)
        begin
            o_phase_next = 1'b0;
        end
        else if (masks.ready)
        begin
            o_phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
            o_phase_reg  <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= b1_valid_next;
            b2_valid_reg <= b2_valid_next;
            o_valid_reg  <= o_valid_next;
            o_phase_reg  <= o_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_en && in_valid)
        begin
            b1_prod_reg  <= prod;
            b1_flags_reg <= in_flags;
        end
        if (b2_en && b1_valid_reg)
        begin
            b2_mask_reg  <= mask;
            b2_flags_reg <= b1_flags_reg;
        end
        if (out_free && b2_valid_reg)
        begin
            o_mask_reg     <= b2_mask_reg;
            o_last_row_reg <= b2_flags_reg.last_row;
            o_last_col_reg <= b2_flags_reg.last_col;
        end
    end

    assign masks.valid        = o_valid_reg;
    assign masks.mask_value   = o_phase_reg ? '0 : o_mask_reg;
    assign masks.end_of_run   = o_phase_reg || !o_last_row_reg;
    assign masks.end_of_frame = o_phase_reg && o_last_col_reg;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the vertical comb mask
// Streams pixel rasters into the block, keeps its own line stores and frame
// position to predict every mask transfer, and compares each transfer on the
// mask channel field by field, in order. Thresholds, depth and geometry are
// programmed over APB between frames (and mid-frame while the block is idle),
// under several idling and back-pressure patterns on both channels.
// ============================================================================
module tb_top;
    import vcm_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int LINE_MAX      = 4096;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 5000;

    typedef struct packed {
        logic [MASK_W-1:0] mask_value;
        logic              end_of_run;
        logic              end_of_frame;
    } mask_item_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    vcm_pixel_if #(.PIXEL_BITS(16)) pix_if ();
    vcm_mask_if                     mask_if ();

    vertical_comb_mask #(
        .MAX_WIDTH (LINE_MAX),
        .PIXEL_BITS(16)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pix_if.sink),
        .masks  (mask_if.source),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    logic signed [THRES_W-1:0] thr_low    = THRES_LOW_RST;
    logic signed [THRES_W-1:0] thr_high   = THRES_HIGH_RST;
    logic [DEPTH_W-1:0]        depth_reg  = DEPTH_RST;
    logic [FW_W-1:0]           width_reg  = WIDTH_RST;
    logic [FH_W-1:0]           height_reg = HEIGHT_RST;

    logic [15:0]  rows_two_back [LINE_MAX];
    logic [15:0]  rows_one_back [LINE_MAX];
    int unsigned  col_pos = 0;
    int unsigned  row_pos = 0;

    mask_item_t   masks_expected[$];
    int           mismatch_count = 0;
    int           results_seen = 0;
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;
    int           ready_holdoff = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int effective_depth();
        if (depth_reg < 5'd8)
            return 8;
        if (depth_reg > 5'd16)
            return 16;
        return int'(depth_reg);
    endfunction

    function automatic int unsigned active_width();
        if (width_reg == '0)
            return 1;
        if (width_reg > LINE_MAX)
            return LINE_MAX;
        return int'(width_reg);
    endfunction

    function automatic int unsigned active_height();
        return (height_reg < 16'd2) ? 2 : int'(height_reg);
    endfunction

    function automatic logic [15:0] comb_value(input logic [15:0] above,
                                               input logic [15:0] centre,
                                               input logic [15:0] below);
        int     eff;
        longint prod;
        longint scaled;
        longint peak;
        longint ceiling;
        eff = effective_depth();
        prod = (longint'(above) - longint'(centre)) * (longint'(below) - longint'(centre));
        prod = prod >>> (eff - 8);
        peak = (longint'(1) << eff) - 1;
        ceiling = (eff == BASE_DEPTH) ? CLAMP8 : 65535;
        if (prod < longint'(thr_low))
            return 16'd0;
        if (prod > longint'(thr_high))
            return peak[15:0];
        scaled = prod >>> FRAC_SHIFT;
        if (scaled < 0)
            scaled = 0;
        if (scaled > ceiling)
            scaled = ceiling;
        return scaled[15:0];
    endfunction

    task automatic predict_masks(input logic [15:0] value);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        logic        last_col;
        logic        last_row;
        mask_item_t  item;
        w = active_width();
        h = active_height();
        x = col_pos;
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);
        if (row_pos >= 1)
        begin
            item.mask_value = (row_pos >= 2) ?
                comb_value(rows_two_back[x], rows_one_back[x], value) : 16'd0;
            item.end_of_run = !last_row;
            item.end_of_frame = 1'b0;
            masks_expected.push_back(item);
            if (last_row)
            begin
                item.mask_value = 16'd0;
                item.end_of_run = 1'b1;
                item.end_of_frame = last_col;
                masks_expected.push_back(item);
            end
        end
        rows_two_back[x] = rows_one_back[x];
        rows_one_back[x] = value;
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((row_pos + 1) & 16'hFFFF);
        end
        else
        begin
            col_pos = (col_pos + 1) & 12'hFFF;
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("tb_top: mismatch at %0t ns: %s", $realtime, msg);
    endtask

    task automatic write_reg(input vcm_reg_t which, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        case (which)
            REG_THRES_LOW:    thr_low = value[THRES_W-1:0];
            REG_THRES_HIGH:   thr_high = value[THRES_W-1:0];
            REG_BIT_DEPTH:    depth_reg = value[DEPTH_W-1:0];
            REG_FRAME_WIDTH:  width_reg = value[FW_W-1:0];
            REG_FRAME_HEIGHT: height_reg = value[FH_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_pixel(input logic [15:0] value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(negedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= value;
        @(posedge clk);
        while (pix_if.ready !== 1'b1)
            @(posedge clk);
        predict_masks(value);
        @(negedge clk);
    endtask

    function automatic logic [15:0] random_pixel();
        int unsigned top;
        top = (32'd1 << effective_depth()) - 1;
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return 16'd0;
            2:       return 16'(top);
            default: return 16'($urandom_range(top));
        endcase
    endfunction

    task automatic send_random_pixels(input int unsigned count);
        repeat (count)
            send_pixel(random_pixel());
    endtask

    task automatic send_pattern(input logic [15:0] pattern[$]);
        foreach (pattern[i])
            send_pixel(pattern[i]);
    endtask

    task automatic wait_results_clear();
        pix_if.valid <= 1'b0;
        while (masks_expected.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle_results();
        wait_results_clear();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic randomize_geometry();
        logic [FW_W-1:0] w;
        logic [FH_W-1:0] h;
        case ($urandom_range(19))
            0:             w = '0;
            1, 2, 3, 4, 5: w = FW_W'($urandom_range(64, 13));
            default:       w = FW_W'($urandom_range(12, 1));
        endcase
        h = (w > 32) ? FH_W'($urandom_range(4)) : FH_W'($urandom_range(8));
        write_reg(REG_FRAME_WIDTH, 32'(w));
        write_reg(REG_FRAME_HEIGHT, 32'(h));
    endtask

    task automatic randomize_thresholds();
        int lo;
        int hi;
        case ($urandom_range(3))
            0:
            begin
                lo = $urandom;
                hi = $urandom;
            end
            1:
            begin
                lo = -int'($urandom_range(4096));
                hi = 16777215;
            end
            2:
            begin
                lo = $urandom_range(65535);
                hi = $urandom_range(4000000, 65536);
            end
            default:
            begin
                lo = -16777216;
                hi = $urandom_range(300000);
            end
        endcase
        write_reg(REG_THRES_LOW, 32'(lo));
        write_reg(REG_THRES_HIGH, 32'(hi));
    endtask

    task automatic randomize_depth();
        if ($urandom_range(4) == 0)
            write_reg(REG_BIT_DEPTH, 32'($urandom_range(31)));
        else
            write_reg(REG_BIT_DEPTH, 32'(8 + 2 * $urandom_range(4)));
    endtask

    task automatic test_directed_extremes();
        logic [15:0] pattern[$];
        write_reg(REG_BIT_DEPTH, 32'd0);
        write_reg(REG_FRAME_WIDTH, 32'd4);
        write_reg(REG_FRAME_HEIGHT, 32'd3);
        pattern = {16'd0, 16'd65535, 16'd0, 16'd12345,
                   16'd65535, 16'd0, 16'd32768, 16'd100,
                   16'd0, 16'd0, 16'd65535, 16'd116};
        send_pattern(pattern);
        settle_results();

        write_reg(REG_THRES_LOW, 32'hFF00_0000);
        write_reg(REG_THRES_HIGH, 32'h00FF_FFFF);
        write_reg(REG_BIT_DEPTH, 32'd31);
        write_reg(REG_FRAME_WIDTH, 32'd0);
        write_reg(REG_FRAME_HEIGHT, 32'd5);
        pattern = {16'd65535, 16'd0, 16'd65535, 16'd32768, 16'd0};
        send_pattern(pattern);
        settle_results();

        write_reg(REG_FRAME_WIDTH, 32'd3);
        write_reg(REG_FRAME_HEIGHT, 32'd0);
        pattern = {16'd255, 16'd0, 16'd255, 16'd0, 16'd255, 16'd128};
        send_pattern(pattern);
        settle_results();
    endtask

    task automatic test_random_traffic();
        int          idle_plan[4];
        int          stall_plan[4];
        int unsigned phase_items;
        idle_plan = '{0, 60, 0, 31};
        stall_plan = '{0, 0, 60, 31};
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = idle_plan[phase];
            receiver_stall_pct = stall_plan[phase];
            phase_items = 0;
            randomize_thresholds();
            randomize_depth();
            randomize_geometry();
            while (phase_items < 200)
            begin
                phase_items += active_width() * active_height();
                send_random_pixels(active_width() * active_height());
                settle_results();
                if ($urandom_range(1) == 0)
                    randomize_geometry();
                if ($urandom_range(2) == 0)
                    randomize_thresholds();
                if ($urandom_range(4) == 0)
                    randomize_depth();
            end
        end
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 31;
        write_reg(REG_FRAME_WIDTH, 32'd7);
        write_reg(REG_FRAME_HEIGHT, 32'd6);
        ready_holdoff = 300;
        send_random_pixels(20);
        wait_results_clear();
        send_random_pixels(22);
        settle_results();
    endtask

    task automatic test_geometry_midframe();
        sender_idle_pct = 31;
        receiver_stall_pct = 31;
        write_reg(REG_THRES_LOW, -32'sd1000);
        write_reg(REG_THRES_HIGH, 32'd2000000);
        write_reg(REG_BIT_DEPTH, 32'd10);
        write_reg(REG_FRAME_WIDTH, 32'd12);
        write_reg(REG_FRAME_HEIGHT, 32'd65535);
        send_random_pixels(43);
        settle_results();
        write_reg(REG_FRAME_WIDTH, 32'd5);
        send_random_pixels(9);
        settle_results();
        write_reg(REG_FRAME_HEIGHT, 32'd2);
        send_random_pixels(2);
        settle_results();
        write_reg(REG_FRAME_HEIGHT, 32'd4);
        send_random_pixels(20);
        settle_results();
    endtask

    task automatic test_wide_frame();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        write_reg(REG_THRES_LOW, 32'hFF00_0000);
        write_reg(REG_THRES_HIGH, 32'h00FF_FFFF);
        write_reg(REG_BIT_DEPTH, 32'd16);
        write_reg(REG_FRAME_WIDTH, 32'd64);
        write_reg(REG_FRAME_HEIGHT, 32'd3);
        send_random_pixels(active_width() * active_height());
        settle_results();
    endtask

    initial
    begin
        mask_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (ready_holdoff > 0)
            begin
                mask_if.ready <= 1'b0;
                ready_holdoff--;
            end
            else
            begin
                mask_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        mask_item_t want;
        if (rst_n && mask_if.valid === 1'b1 && mask_if.ready === 1'b1)
        begin
            results_seen++;
            if (masks_expected.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transfer %0d, mask_value %0d",
                                          results_seen, mask_if.mask_value));
            end
            else
            begin
                want = masks_expected.pop_front();
                if (mask_if.mask_value !== want.mask_value)
                    report_mismatch($sformatf("transfer %0d mask_value %0d, expected %0d",
                                              results_seen, mask_if.mask_value,
                                              want.mask_value));
                if (mask_if.end_of_run !== want.end_of_run)
                    report_mismatch($sformatf("transfer %0d end_of_run %0b, expected %0b",
                                              results_seen, mask_if.end_of_run,
                                              want.end_of_run));
                if (mask_if.end_of_frame !== want.end_of_frame)
                    report_mismatch($sformatf("transfer %0d end_of_frame %0b, expected %0b",
                                              results_seen, mask_if.end_of_frame,
                                              want.end_of_frame));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((pix_if.valid === 1'b1 && pix_if.ready === 1'b1) ||
                (mask_if.valid === 1'b1 && mask_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_extremes();
        test_random_traffic();
        test_backpressure();
        test_geometry_midframe();
        test_wide_frame();

        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
